// ----- hdl/bigram_frequency_filter_top_defines.svh -----
// Assertion macros shared by the bigram frequency filter checker
`ifndef BIGRAM_FREQUENCY_FILTER_TOP_DEFINES_SVH
`define BIGRAM_FREQUENCY_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define BFF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bigram filter check failed");

// Next-cycle implication, disabled while reset is asserted
`define BFF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bigram filter check failed");

`endif

// ----- hdl/bff_pkg.sv -----
// Types and constants of the bigram frequency filter
`default_nettype none
package bff_pkg;

	localparam int WIDE_W = 13;
	localparam logic [7:0] NEWLINE_CHAR = 8'd10;
	localparam logic [7:0] THRESHOLD_RESET = 8'd20;
	localparam logic [7:0] COUNT_MAX = 8'hFF;
	localparam logic [1:0] LINE_SAT = 2'd2;

	typedef enum logic [1:0] {
		MODE_LOAD = 2'd0,
		MODE_CHAR = 2'd1,
		MODE_READ = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ_OUT
	} state_t;

	typedef struct packed {
		logic       alive;
		logic [7:0] first;
		logic [7:0] second;
		logic [7:0] count;
	} entry_t;

	typedef struct packed {
		logic accept;
		logic scan;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic pair_now;
		logic read_now;
		logic scan_done;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

// ----- hdl/bff_ctrl.sv -----
// Controller state machine of the bigram frequency filter
`default_nettype none
module bff_ctrl
	import bff_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire status_t st,
	output cmd_t         cmd
);

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (st.pair_now) begin
						state_next = ST_SCAN;
					end else if (st.read_now) begin
						state_next = ST_READ_OUT;
					end
				end
			end
			ST_SCAN: begin
				if (st.scan_done) begin
					state_next = ST_IDLE;
				end
			end
			ST_READ_OUT: begin
				if (st.out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.accept = in_valid;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_READ_OUT: begin
				cmd.out_load = st.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- hdl/bff_datapath.sv -----
// Datapath of the bigram frequency filter: entry table, scan pipe, output word
`default_nettype none
module bff_datapath
	import bff_pkg::*;
#(
	parameter int TABLE_ENTRIES = 1024
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cmd_t       cmd,
	output status_t         st,
	input  wire logic [1:0] mode,
	input  wire logic [7:0] first_byte,
	input  wire logic [7:0] second_byte,
	input  wire logic [9:0] entry_index,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic       out_ready,
	output logic            out_valid,
	output logic [9:0]      read_index,
	output logic            loaded,
	output logic            alive,
	output logic [7:0]      bigram_first,
	output logic [7:0]      bigram_second,
	output logic [7:0]      hit_count
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);

	entry_t mem [TABLE_ENTRIES];

	mode_t            mode_e;
	logic [7:0]       thr_q;
	logic [FILL_W-1:0] fill_q;
	logic [1:0]       line_pos_q;
	logic [7:0]       prior_char_q;
	logic [7:0]       pair_a_q;
	logic [7:0]       pair_b_q;
	logic [9:0]       idx_q;
	logic [FILL_W-1:0] rd_ptr_q;
	logic             vld_s1;
	logic [IDX_W-1:0] addr_s1;
	entry_t           mem_rd_s1;
	logic             out_valid_q;

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;
	logic             scan_more;
	logic             load_en;
	logic             char_en;
	logic             hit;
	logic [7:0]       cnt_inc;
	logic [WIDE_W-1:0] idx_ext;
	logic             read_ok;

	assign mode_e = mode_t'(mode);
	assign idx_ext = WIDE_W'(entry_index);
	assign scan_more = rd_ptr_q < fill_q;
	assign load_en = cmd.accept && (mode_e == MODE_LOAD)
		&& (fill_q < FILL_W'(TABLE_ENTRIES));
	assign char_en = cmd.accept && (mode_e == MODE_CHAR);
	assign hit = vld_s1 && mem_rd_s1.alive
		&& (mem_rd_s1.first == pair_a_q) && (mem_rd_s1.second == pair_b_q);
	assign cnt_inc = (mem_rd_s1.count == COUNT_MAX) ? COUNT_MAX : mem_rd_s1.count + 8'd1;
	assign read_ok = WIDE_W'(idx_q) < WIDE_W'(fill_q);

	assign st.pair_now = (mode_e == MODE_CHAR) && (first_byte != NEWLINE_CHAR)
		&& (line_pos_q != 2'd0);
	assign st.read_now = (mode_e == MODE_READ);
	assign st.scan_done = !scan_more && !vld_s1;
	assign st.out_free = !out_valid_q || out_ready;

	always_comb begin
		rd_en = 1'b0;
		rd_addr = '0;
		if (cmd.accept && (mode_e == MODE_READ)) begin
			rd_en = 1'b1;
			rd_addr = idx_ext[IDX_W-1:0];
		end else if (cmd.scan && scan_more) begin
			rd_en = 1'b1;
			rd_addr = rd_ptr_q[IDX_W-1:0];
		end
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		if (load_en) begin
			wr_en = 1'b1;
			wr_addr = fill_q[IDX_W-1:0];
			wr_data.alive = 1'b1;
			wr_data.first = first_byte;
			wr_data.second = second_byte;
			wr_data.count = 8'd0;
		end else if (hit) begin
			// bump the count, kill the entry once it reaches the threshold
			wr_en = 1'b1;
			wr_addr = addr_s1;
			wr_data.alive = !(cnt_inc >= thr_q);
			wr_data.first = mem_rd_s1.first;
			wr_data.second = mem_rd_s1.second;
			wr_data.count = cnt_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
			fill_q <= '0;
			line_pos_q <= 2'd0;
			prior_char_q <= 8'd0;
			rd_ptr_q <= '0;
			vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (load_en) begin
				fill_q <= fill_q + FILL_W'(1);
			end
			if (char_en) begin
				prior_char_q <= first_byte;
				rd_ptr_q <= '0;
				if (first_byte == NEWLINE_CHAR) begin
					line_pos_q <= 2'd0;
				end else if (line_pos_q != LINE_SAT) begin
					line_pos_q <= line_pos_q + 2'd1;
				end
			end else if (cmd.scan && scan_more) begin
				rd_ptr_q <= rd_ptr_q + FILL_W'(1);
			end
			vld_s1 <= cmd.scan && scan_more;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (char_en) begin
			pair_a_q <= prior_char_q;
			pair_b_q <= first_byte;
		end
		if (cmd.accept) begin
			idx_q <= entry_index;
		end
		if (cmd.scan && scan_more) begin
			addr_s1 <= rd_ptr_q[IDX_W-1:0];
		end
		if (cmd.out_load) begin
			read_index <= idx_q;
			loaded <= read_ok;
			alive <= read_ok && mem_rd_s1.alive;
			bigram_first <= read_ok ? mem_rd_s1.first : 8'd0;
			bigram_second <= read_ok ? mem_rd_s1.second : 8'd0;
			hit_count <= read_ok ? mem_rd_s1.count : 8'd0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ----- hdl/bigram_frequency_filter_top.sv -----
// Top level of the bigram frequency filter
`default_nettype none
// Holds up to TABLE_ENTRIES bigrams in a single-port-write, single-port-read RAM
// and counts their occurrences in streamed text. A load word leaves the controller
// idle; a read word passes through the read-out state, with its result parked in
// an output register so the next word can come in while it waits. A text character
// that closes a bigram walks the whole loaded table through the RAM read port, one
// entry per cycle with write-back of a hit in the cycle after its read, and holds
// the block until the scan drains; other characters leave the controller idle.
// No clearing pass after reset: entries at or above the fill count read as empty.
module bigram_frequency_filter_top
	import bff_pkg::*;
#(
	parameter int TABLE_ENTRIES = 1024
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] mode,
	input  wire logic [7:0] first_byte,
	input  wire logic [7:0] second_byte,
	input  wire logic [9:0] entry_index,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [9:0]      read_index,
	output logic            loaded,
	output logic            alive,
	output logic [7:0]      bigram_first,
	output logic [7:0]      bigram_second,
	output logic [7:0]      hit_count
);

	cmd_t    cmd;
	status_t st;

	bff_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	bff_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.mode          (mode),
		.first_byte    (first_byte),
		.second_byte   (second_byte),
		.entry_index   (entry_index),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.read_index    (read_index),
		.loaded        (loaded),
		.alive         (alive),
		.bigram_first  (bigram_first),
		.bigram_second (bigram_second),
		.hit_count     (hit_count)
	);

endmodule
`default_nettype wire

// ----- hdl/bff_checker.sv -----
// Port-level checker of the bigram frequency filter and its bind
`default_nettype none
`include "bigram_frequency_filter_top_defines.svh"
module bff_checker #(
	parameter int TABLE_ENTRIES = 1024
) (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [9:0] read_index,
	input wire logic       loaded,
	input wire logic       alive,
	input wire logic [7:0] bigram_first,
	input wire logic [7:0] bigram_second,
	input wire logic [7:0] hit_count
);

	// a stalled result word stays up
	`BFF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// and keeps its index, loaded and alive flags and hit count
	`BFF_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready,
		$stable(read_index) && $stable(loaded) && $stable(alive) && $stable(hit_count))

	// an empty slot reports all-zero contents
	`BFF_ASSERT_NOW(a_empty_zero, clk, arst_n, out_valid && !loaded,
		!alive && bigram_first == 8'd0 && bigram_second == 8'd0 && hit_count == 8'd0)

	// only slots inside the table can be loaded
	`BFF_ASSERT_NOW(a_loaded_range, clk, arst_n, out_valid && loaded,
		32'(read_index) < TABLE_ENTRIES)

	// a fresh result does not rise with in_ready high straight after a word taken from a settled idle
	`BFF_ASSERT_NOW(a_result_cause, clk, arst_n, $rose(out_valid),
		!in_ready || !$past(in_valid && in_ready) || !$past(in_ready, 2))

endmodule

bind bigram_frequency_filter_top bff_checker #(
	.TABLE_ENTRIES (TABLE_ENTRIES)
) u_bff_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.read_index    (read_index),
	.loaded        (loaded),
	.alive         (alive),
	.bigram_first  (bigram_first),
	.bigram_second (bigram_second),
	.hit_count     (hit_count)
);
`default_nettype wire
